// ===== rtl/lrr_pkg.sv =====
// ----------------------------------------------------------------------------
// lrr_pkg
// shared constants for the letterbox render rectangle block
// ----------------------------------------------------------------------------
package lrr_pkg;

    localparam int COORD_WIDTH = 13;
    localparam int AR_W        = 12;
    localparam int PAR_W       = 8;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int STATUS_W    = 2;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_LEFT   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_TOP    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_RIGHT  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_VIEW_BOTTOM = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FORCED_AR_W = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FORCED_AR_H = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_SIZE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO_SCALED = 2'd2;

endpackage

// ===== rtl/lrr_div_cell.sv =====
// ----------------------------------------------------------------------------
// lrr_div_cell
// one restoring division step, registered, passes its word to the next cell
// ----------------------------------------------------------------------------
module lrr_div_cell #(
    parameter int STEPS = 8,
    parameter int DW    = 8,
    parameter int SW    = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_v,
    input  logic [DW-1:0]    i_rem,
    input  logic [STEPS-1:0] i_num,
    input  logic [DW-1:0]    i_div,
    input  logic [SW-1:0]    i_side,
    output logic             o_v,
    output logic [DW-1:0]    o_rem,
    output logic [STEPS-1:0] o_num,
    output logic [DW-1:0]    o_div,
    output logic [SW-1:0]    o_side
);

    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_ge;
    logic [DW-1:0]    n_rem;
    logic [STEPS-1:0] n_num;
    logic             r_v;
    logic [DW-1:0]    r_rem;
    logic [STEPS-1:0] r_num;
    logic [DW-1:0]    r_div;
    logic [SW-1:0]    r_side;

    always_comb begin
        w_trial = {i_rem, i_num[STEPS-1]};
        w_ge    = (w_trial >= {1'b0, i_div});
        w_diff  = w_trial - {1'b0, i_div};
        n_rem   = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        n_num   = {i_num[STEPS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_en) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_num  <= n_num;
            r_div  <= i_div;
            r_side <= i_side;
        end
    end

    assign o_v    = r_v;
    assign o_rem  = r_rem;
    assign o_num  = r_num;
    assign o_div  = r_div;
    assign o_side = r_side;

endmodule

// ===== rtl/lrr_div_chain.sv =====
// ----------------------------------------------------------------------------
// lrr_div_chain
// row of division cells, one quotient bit per cell, one word in per cycle while i_en is high
// ----------------------------------------------------------------------------
module lrr_div_chain #(
    parameter int STEPS = 8,
    parameter int DW    = 8,
    parameter int SW    = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_v,
    input  logic [DW-1:0]    i_rem,
    input  logic [STEPS-1:0] i_num,
    input  logic [DW-1:0]    i_div,
    input  logic [SW-1:0]    i_side,
    output logic             o_v,
    output logic [STEPS-1:0] o_quot,
    output logic [SW-1:0]    o_side
);

    logic             w_v    [STEPS+1];
    logic [DW-1:0]    w_rem  [STEPS+1];
    logic [STEPS-1:0] w_num  [STEPS+1];
    logic [DW-1:0]    w_div  [STEPS+1];
    logic [SW-1:0]    w_side [STEPS+1];

    assign w_v[0]    = i_v;
    assign w_rem[0]  = i_rem;
    assign w_num[0]  = i_num;
    assign w_div[0]  = i_div;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < STEPS; g++) begin : g_cell
        lrr_div_cell #(.STEPS(STEPS), .DW(DW), .SW(SW)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (i_en),
            .i_v    (w_v[g]),
            .i_rem  (w_rem[g]),
            .i_num  (w_num[g]),
            .i_div  (w_div[g]),
            .i_side (w_side[g]),
            .o_v    (w_v[g+1]),
            .o_rem  (w_rem[g+1]),
            .o_num  (w_num[g+1]),
            .o_div  (w_div[g+1]),
            .o_side (w_side[g+1])
        );
    end

    // remainder of the last cell is not needed
    assign o_v    = w_v[STEPS];
    assign o_quot = w_num[STEPS];
    assign o_side = w_side[STEPS];

endmodule

// ===== rtl/letterbox_render_rect_top.sv =====
// throughput: one word per cycle while the skid entry is empty; the two division cell rows set the depth
// a two-entry output register with skid keeps the pipeline running one word
// past a stalled output; input ready drops only when the skid entry is full
// reset (synchronous, active low) clears all valid bits and sets the view to
// zero and the forced aspect to 1:1
// ----------------------------------------------------------------------------
// letterbox_render_rect_top
// fits a video format into the view rectangle and returns the aligned,
// centered render rectangle
// ----------------------------------------------------------------------------
module letterbox_render_rect_top #(
    parameter int CW = lrr_pkg::COORD_WIDTH
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // video_width, video_height, pixel_ar_num, pixel_ar_den, zero pad
    input  logic [((2*CW+16+7)/8)*8-1:0]         i_s_axis_tdata,
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // render_left, render_top, render_right, render_bottom, zero pad
    output logic [((4*CW+2+7)/8)*8-1:0]          o_m_axis_tdata,
    // status
    output logic [lrr_pkg::STATUS_W-1:0]         o_m_axis_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lrr_pkg::CFG_ADDR_W-1:0]       i_cfg_addr,
    input  logic [lrr_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import lrr_pkg::*;

    localparam int ODW  = ((4*CW+2+7)/8)*8;
    localparam int OPAD = ODW - (4*CW+2);
    localparam int PW   = CW + PAR_W;
    localparam int HW   = (CW > AR_W) ? CW : AR_W;
    localparam int NBW  = CW + PW;
    localparam int SAW  = 2 + 2*CW;

    // configuration
    logic [CW-1:0]   r_vl, r_vt, r_vr, r_vb;
    logic [AR_W-1:0] r_afw, r_afh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vl  <= '0;
            r_vt  <= '0;
            r_vr  <= '0;
            r_vb  <= '0;
            r_afw <= AR_W'(1);
            r_afh <= AR_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                REG_VIEW_LEFT:   r_vl  <= i_cfg_data[CW-1:0];
                REG_VIEW_TOP:    r_vt  <= i_cfg_data[CW-1:0];
                REG_VIEW_RIGHT:  r_vr  <= i_cfg_data[CW-1:0];
                REG_VIEW_BOTTOM: r_vb  <= i_cfg_data[CW-1:0];
                REG_FORCED_AR_W: r_afw <= i_cfg_data[AR_W-1:0];
                REG_FORCED_AR_H: r_afh <= i_cfg_data[AR_W-1:0];
                default: ;
            endcase
        end
    end
    assign o_cfg_ready = 1'b1;

    logic [CW-1:0]   w_gw, w_gh;
    logic [AR_W-1:0] w_aw, w_ah;
    logic            w_forced;

    always_comb begin
        w_gw     = (r_vr >= r_vl) ? (r_vr - r_vl) : '0;
        w_gh     = (r_vb >= r_vt) ? (r_vb - r_vt) : '0;
        w_aw     = (r_afw == '0) ? AR_W'(1) : r_afw;
        w_ah     = (r_afh == '0) ? AR_W'(1) : r_afh;
        w_forced = (w_aw != AR_W'(1)) || (w_ah != AR_W'(1));
    end

    // pipeline advance
    logic r_skid_v;
    logic w_en;
    logic w_acc;
    assign w_en            = !r_skid_v;
    assign o_s_axis_tready = w_en;
    assign w_acc           = i_s_axis_tvalid && w_en;

    // input stage: width times pixel aspect numerator
    logic [CW-1:0]    w_vw, w_vh;
    logic [PAR_W-1:0] w_num, w_den;
    logic             w_square;
    assign w_vw  = i_s_axis_tdata[CW-1:0];
    assign w_vh  = i_s_axis_tdata[2*CW-1:CW];
    assign w_num = i_s_axis_tdata[2*CW+PAR_W-1:2*CW];
    assign w_den = i_s_axis_tdata[2*CW+2*PAR_W-1:2*CW+PAR_W];
    assign w_square = (w_num <= PAR_W'(1)) && (w_den <= PAR_W'(1));

    logic             r_s0_v;
    logic [PW-1:0]    r_s0_prod;
    logic [PAR_W-1:0] r_s0_den;
    logic [SAW-1:0]   r_s0_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_v <= 1'b0;
        end else if (w_en) begin
            r_s0_v <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s0_prod <= PW'(w_vw) * PW'(w_num);
            r_s0_den  <= (w_den == '0) ? PAR_W'(1) : w_den;
            r_s0_side <= {(w_vw == '0) || (w_vh == '0), !w_forced && !w_square, w_vw, w_vh};
        end
    end

    // scaled width = product / denominator
    logic           w_a_v;
    logic [PW-1:0]  w_a_q;
    logic [SAW-1:0] w_a_side;

    lrr_div_chain #(.STEPS(PW), .DW(PAR_W), .SW(SAW)) u_div_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (r_s0_v),
        .i_rem  ('0),
        .i_num  (r_s0_prod),
        .i_div  (r_s0_den),
        .i_side (r_s0_side),
        .o_v    (w_a_v),
        .o_quot (w_a_q),
        .o_side (w_a_side)
    );

    logic          w_a_zero, w_a_usesw;
    logic [CW-1:0] w_a_vw, w_a_vh;
    assign {w_a_zero, w_a_usesw, w_a_vw, w_a_vh} = w_a_side;

    // shape select
    logic                r_s1_v;
    logic [PW-1:0]       r_s1_sw;
    logic [HW-1:0]       r_s1_sh;
    logic [STATUS_W-1:0] r_s1_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (w_en) begin
            r_s1_v <= w_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_forced) begin
                r_s1_sw <= PW'(w_aw);
                r_s1_sh <= HW'(w_ah);
            end else begin
                r_s1_sw <= w_a_usesw ? w_a_q : PW'(w_a_vw);
                r_s1_sh <= HW'(w_a_vh);
            end
            if (w_a_zero) begin
                r_s1_st <= ST_ZERO_SIZE;
            end else if (w_a_usesw && (w_a_q == '0)) begin
                r_s1_st <= ST_ZERO_SCALED;
            end else begin
                r_s1_st <= ST_OK;
            end
        end
    end

    // cross products of view and shape
    logic                r_s2_v;
    logic [NBW-1:0]      r_s2_p1, r_s2_p2;
    logic [PW-1:0]       r_s2_sw;
    logic [HW-1:0]       r_s2_sh;
    logic [STATUS_W-1:0] r_s2_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (w_en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_p1 <= NBW'(w_gh) * NBW'(r_s1_sw);
            r_s2_p2 <= NBW'(w_gw) * NBW'(r_s1_sh);
            r_s2_sw <= r_s1_sw;
            r_s2_sh <= r_s1_sh;
            r_s2_st <= r_s1_st;
        end
    end

    // fitted side: quotient fits CW bits, so only CW steps are run
    logic           w_cmp;
    logic [NBW-1:0] w_b_n;
    logic [PW-1:0]  w_b_d;
    always_comb begin
        w_cmp = (r_s2_p1 >= r_s2_p2);
        w_b_n = w_cmp ? r_s2_p2 : r_s2_p1;
        w_b_d = w_cmp ? r_s2_sw : PW'(r_s2_sh);
    end

    logic                  w_b_v;
    logic [CW-1:0]         w_b_q;
    logic [STATUS_W:0]     w_b_side;

    lrr_div_chain #(.STEPS(CW), .DW(PW), .SW(STATUS_W+1)) u_div_fit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_v    (r_s2_v),
        .i_rem  (w_b_n[NBW-1:CW]),
        .i_num  (w_b_n[CW-1:0]),
        .i_div  (w_b_d),
        .i_side ({w_cmp, r_s2_st}),
        .o_v    (w_b_v),
        .o_quot (w_b_q),
        .o_side (w_b_side)
    );

    // centering and alignment
    logic [CW-1:0]       w_w, w_h;
    logic [CW:0]         w_left, w_top;
    logic [CW+1:0]       w_right, w_bottom;
    logic [CW-1:0]       w_l_al, w_t_al;
    logic [CW:0]         w_r_al, w_b_al;
    logic [ODW-1:0]      w_odata;
    logic [STATUS_W-1:0] w_ost;

    always_comb begin
        w_w      = w_b_side[STATUS_W] ? w_gw : w_b_q;
        w_h      = w_b_side[STATUS_W] ? w_b_q : w_gh;
        w_left   = {1'b0, r_vl} + {1'b0, (w_gw - w_w) >> 1};
        w_top    = {1'b0, r_vt} + {1'b0, (w_gh - w_h) >> 1};
        w_right  = {1'b0, w_left} + {2'b00, w_w} + (CW+2)'(3);
        w_bottom = {1'b0, w_top} + {2'b00, w_h} + (CW+2)'(1);
        w_l_al   = {w_left[CW-1:2], 2'b00};
        w_t_al   = {w_top[CW-1:1], 1'b0};
        w_r_al   = {w_right[CW:2], 2'b00};
        w_b_al   = {w_bottom[CW:1], 1'b0};
        w_ost    = w_b_side[STATUS_W-1:0];
        if (w_ost == ST_OK) begin
            w_odata = {{OPAD{1'b0}}, w_b_al, w_r_al, w_t_al, w_l_al};
        end else begin
            w_odata = '0;
        end
    end

    // output register with skid entry
    logic                r_out_v;
    logic [ODW-1:0]      r_out_data, r_skid_data;
    logic [STATUS_W-1:0] r_out_st, r_skid_st;
    logic                w_take;
    assign w_take = r_out_v && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (w_take) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_b_v) begin
            if (r_out_v && !w_take) begin
                r_skid_v <= 1'b1;
            end
            r_out_v <= 1'b1;
        end else if (w_take) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
                r_out_st   <= r_skid_st;
            end
        end else if (w_b_v) begin
            if (r_out_v && !w_take) begin
                r_skid_data <= w_odata;
                r_skid_st   <= w_ost;
            end else begin
                r_out_data <= w_odata;
                r_out_st   <= w_ost;
            end
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_st;

endmodule

// ===== rtl/lrr_checker.sv =====
// ----------------------------------------------------------------------------
// lrr_checker
// port-level checks for the letterbox render rectangle block
// ----------------------------------------------------------------------------
module lrr_checker #(
    parameter int CW = lrr_pkg::COORD_WIDTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_axis_tready,
    input logic                           o_m_axis_tvalid,
    input logic                           i_m_axis_tready,
    input logic [((4*CW+2+7)/8)*8-1:0]    o_m_axis_tdata,
    input logic [lrr_pkg::STATUS_W-1:0]   o_m_axis_tuser
);
    import lrr_pkg::*;

    // status is one of the three defined codes
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == ST_OK || o_m_axis_tuser == ST_ZERO_SIZE ||
                             o_m_axis_tuser == ST_ZERO_SCALED))
        else $error("bad status code");

    // error words carry a zero rectangle
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != ST_OK) |-> (o_m_axis_tdata == '0))
        else $error("nonzero rectangle with error status");

    // left is a multiple of 4, top a multiple of 2
    a_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] == 2'b00 && o_m_axis_tdata[CW] == 1'b0))
        else $error("render rectangle not aligned");

    // input backpressure only while a word waits at the output
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("output word changed while stalled");

endmodule

bind letterbox_render_rect_top lrr_checker #(.CW(CW)) u_lrr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata),
    .o_m_axis_tuser (o_m_axis_tuser)
);
